// ===== sv/ccss_pkg.sv =====
// shared types, constants and the sine table of the splitting search
// used by every module of the block but ccss_ram, depends on nothing
package ccss_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int MAX_LAG_DEF     = 64;
  localparam int ANGLE_STEPS_DEF = 180;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int FIELD_W = 16;
  localparam int CFG_W   = 16;
  localparam int ANGLE_W = 8;
  localparam int LAGO_W  = 7;
  localparam int RATIO_W = 17;

  localparam logic [1:0] CFG_RT_MODE = 2'd0;
  localparam logic [1:0] CFG_MAX_LAG = 2'd1;
  localparam logic [1:0] CFG_COS_BAZ = 2'd2;
  localparam logic [1:0] CFG_SIN_BAZ = 2'd3;

  localparam int COEF_W   = 18;
  localparam int ENERGY_W = 63;
  localparam int DEN_W    = 64;
  localparam logic [ENERGY_W-1:0] ENERGY_CAP = {1'b1, {(ENERGY_W-1){1'b0}}};
  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

  typedef struct packed {
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
  } coef_t;

  localparam logic [15:0] SINE_ROM [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
  };

  function automatic logic [15:0] sine_lookup(input logic [6:0] d);
    logic [15:0] v;
    v = 16'd0;
    if (d <= 7'd90) begin
      v = SINE_ROM[d];
    end
    return v;
  endfunction

  // accumulate with saturation at the energy cap
  function automatic logic [ENERGY_W-1:0] sat_add(input logic [ENERGY_W-1:0] acc,
                                                  input logic [ENERGY_W-1:0] v);
    logic [ENERGY_W:0] t;
    t = {1'b0, acc} + {1'b0, v};
    return (t > {1'b0, ENERGY_CAP}) ? ENERGY_CAP : t[ENERGY_W-1:0];
  endfunction

endpackage

// ===== sv/cross_convolution_splitting_search.sv =====
// channel   | dir | handshake               | payload
// input     | in  | in_valid_i / in_stall_o | sample_first, sample_second, last_sample
// result    | out | out_valid_o / out_stall_i | best_angle, best_lag, best_ratio, short_trace
// config    | in  | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// loading takes one item per cycle into two sample rams (one write, two reads each)
// a search runs after the item marked last; per angle the coefficient sequencer
// computes sine products (rt), plus the back-azimuth rotation (ne); per grid point there
// are a ram scan of n pairs, pipeline drain and serial compare, then a final divide
// input is stalled during the search, and a last item is stalled while a result waits
// reset clears control state and restores the register defaults; no ram clearing
//
// top level of the cross-convolution splitting grid search; depends on ccss_pkg,
// ccss_ram, ccss_coef, ccss_energy, ccss_cmp, ccss_div
module cross_convolution_splitting_search #(
  parameter int MAX_SAMPLES = ccss_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_LAG     = ccss_pkg::MAX_LAG_DEF,
  parameter int ANGLE_STEPS = ccss_pkg::ANGLE_STEPS_DEF,
  parameter int SAMPLE_BITS = ccss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [ccss_pkg::FIELD_W-1:0] sample_first_i,
  input  logic signed [ccss_pkg::FIELD_W-1:0] sample_second_i,
  input  logic                               last_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ccss_pkg::ANGLE_W-1:0]       best_angle_o,
  output logic [ccss_pkg::LAGO_W-1:0]        best_lag_o,
  output logic [ccss_pkg::RATIO_W-1:0]       best_ratio_o,
  output logic                               short_trace_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [ccss_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int LAG_W  = $clog2(MAX_LAG + 1);
  localparam int ANG_W  = $clog2(ANGLE_STEPS);
  localparam int LIM_W0 = (CNT_W > LAG_W) ? CNT_W : LAG_W;
  localparam int LIM_W  = (LIM_W0 > 7) ? LIM_W0 : 7;
  localparam int DEG_INC  = 180 / ANGLE_STEPS;
  localparam int DEG_FRAC = 180 % ANGLE_STEPS;
  localparam int EW = ccss_pkg::ENERGY_W;
  localparam int DW = ccss_pkg::DEN_W;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'h01,
    ST_COEF  = 8'h02,
    ST_PREP  = 8'h04,
    ST_RUN   = 8'h08,
    ST_DRAIN = 8'h10,
    ST_CMP   = 8'h20,
    ST_NEXT  = 8'h40,
    ST_DIV   = 8'h80
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic rt_mode_q;
  logic [6:0] max_lag_q;
  logic signed [ccss_pkg::CFG_W-1:0] cos_baz_q, sin_baz_q;

  // load and search counters
  logic [CNT_W-1:0] cnt_q, n_q, n_new;
  logic [LAG_W-1:0] lim_q, lag_q;
  logic [ANG_W-1:0] k_q;
  logic [ccss_pkg::ANGLE_W-1:0] deg_q;
  logic [ANG_W-1:0] deg_rem_q;
  logic [ANG_W:0] rem_sum;
  logic [AW-1:0] i_q, j_q;
  logic [LIM_W-1:0] ml, nm1, lim;

  // best grid point so far
  logic [EW-1:0] best_e_q;
  logic [DW-1:0] best_d_q;
  logic [ccss_pkg::ANGLE_W-1:0] best_deg_q;
  logic [LAG_W-1:0] best_lag_q;
  logic first_q;

  // result register
  logic out_valid_q, short_q;
  logic [ccss_pkg::ANGLE_W-1:0] out_angle_q;
  logic [ccss_pkg::LAGO_W-1:0] out_lag_q;
  logic [ccss_pkg::RATIO_W-1:0] out_ratio_q;

  logic in_acc, store_we, issue, i_last, rd_v_q, rd_last_q;
  logic coef_start, coef_start_q, coef_done, cmp_start, cmp_done, cmp_less;
  logic div_start, div_done, e_clear, e_done, take_best;
  ccss_pkg::coef_t coef;
  logic [SAMPLE_BITS-1:0] x_rd, xj_rd, y_rd, yj_rd;
  logic [EW-1:0] en;
  logic [DW-1:0] den;
  logic [ccss_pkg::RATIO_W-1:0] ratio;

  // a last item waits while an earlier result is still held
  assign in_stall_o = (state_q != ST_LOAD) || (out_valid_q && last_sample_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_we   = in_acc && (cnt_q < CNT_W'(MAX_SAMPLES));
  assign n_new      = cnt_q + CNT_W'(store_we);

  // lag limit: zero counts as one, then clamp to MAX_LAG and n-1
  always_comb begin
    ml = (max_lag_q == 7'd0) ? LIM_W'(1) : LIM_W'(max_lag_q);
    if (ml > LIM_W'(MAX_LAG)) begin
      ml = LIM_W'(MAX_LAG);
    end
    nm1 = LIM_W'(n_new) - LIM_W'(1);
    lim = (ml > nm1) ? nm1 : ml;
  end

  assign rem_sum = {1'b0, deg_rem_q} + (ANG_W + 1)'(DEG_FRAC);
  assign i_last  = (i_q == AW'(n_q - CNT_W'(1)));
  assign issue   = (state_q == ST_RUN);
  assign e_clear = (state_q == ST_PREP);
  assign take_best = ((state_q == ST_DRAIN) && e_done && first_q) ||
                     ((state_q == ST_CMP) && cmp_done && cmp_less);

  always_comb begin
    state_d    = state_q;
    coef_start = 1'b0;
    cmp_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && last_sample_i && (n_new >= CNT_W'(2))) begin
          state_d    = ST_COEF;
          coef_start = 1'b1;
        end
      end
      ST_COEF: if (coef_done) state_d = ST_PREP;
      ST_PREP: state_d = ST_RUN;
      ST_RUN:  if (i_last) state_d = ST_DRAIN;
      ST_DRAIN: begin
        if (e_done) begin
          if (first_q) begin
            state_d = ST_NEXT;
          end else begin
            cmp_start = 1'b1;
            state_d   = ST_CMP;
          end
        end
      end
      ST_CMP: if (cmp_done) state_d = ST_NEXT;
      ST_NEXT: begin
        if (lag_q == lim_q) begin
          if (k_q == ANG_W'(ANGLE_STEPS - 1)) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            coef_start = 1'b1;
            state_d    = ST_COEF;
          end
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_DIV: if (div_done) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      cnt_q        <= '0;
      coef_start_q <= 1'b0;
      rd_v_q       <= 1'b0;
      rd_last_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      first_q      <= 1'b0;
      rt_mode_q    <= 1'b1;
      max_lag_q    <= 7'd32;
      cos_baz_q    <= 16'sd32767;
      sin_baz_q    <= 16'sd0;
    end else begin
      state_q      <= state_d;
      coef_start_q <= coef_start;
      rd_v_q       <= issue;
      rd_last_q    <= issue && i_last;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ccss_pkg::CFG_RT_MODE: rt_mode_q <= cfg_data_i[0];
          ccss_pkg::CFG_MAX_LAG: max_lag_q <= cfg_data_i[6:0];
          ccss_pkg::CFG_COS_BAZ: cos_baz_q <= cfg_data_i;
          ccss_pkg::CFG_SIN_BAZ: sin_baz_q <= cfg_data_i;
        endcase
      end

      if (in_acc) begin
        cnt_q <= last_sample_i ? '0 : n_new;
      end

      if ((state_q == ST_LOAD) && (state_d == ST_COEF)) begin
        first_q <= 1'b1;
      end else if (take_best) begin
        first_q <= 1'b0;
      end

      // the result register is free whenever a search finishes
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((in_acc && last_sample_i && (n_new < CNT_W'(2))) ||
          ((state_q == ST_DIV) && div_done)) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_LOAD) && (state_d == ST_COEF)) begin
      n_q       <= n_new;
      lim_q     <= LAG_W'(lim);
      lag_q     <= LAG_W'(1);
      k_q       <= '0;
      deg_q     <= '0;
      deg_rem_q <= '0;
    end
    if ((state_q == ST_NEXT) && (state_d == ST_COEF)) begin
      k_q   <= k_q + 1'b1;
      lag_q <= LAG_W'(1);
      if (rem_sum >= (ANG_W + 1)'(ANGLE_STEPS)) begin
        deg_rem_q <= ANG_W'(rem_sum - (ANG_W + 1)'(ANGLE_STEPS));
        deg_q     <= deg_q + ccss_pkg::ANGLE_W'(DEG_INC + 1);
      end else begin
        deg_rem_q <= ANG_W'(rem_sum);
        deg_q     <= deg_q + ccss_pkg::ANGLE_W'(DEG_INC);
      end
    end
    if ((state_q == ST_NEXT) && (state_d == ST_PREP)) begin
      lag_q <= lag_q + 1'b1;
    end

    // circular partner index j = i - lag, wrapping at n
    if (state_q == ST_PREP) begin
      i_q <= '0;
      j_q <= AW'(LIM_W'(n_q) - LIM_W'(lag_q));
    end else if (issue) begin
      i_q <= i_q + 1'b1;
      j_q <= ((CNT_W'(j_q) + CNT_W'(1)) == n_q) ? '0 : j_q + 1'b1;
    end

    if (take_best) begin
      best_e_q   <= en;
      best_d_q   <= den;
      best_deg_q <= deg_q;
      best_lag_q <= lag_q;
    end

    if (in_acc && last_sample_i && (n_new < CNT_W'(2))) begin
      out_angle_q <= '0;
      out_lag_q   <= '0;
      out_ratio_q <= '0;
      short_q     <= 1'b1;
    end else if ((state_q == ST_DIV) && div_done) begin
      out_angle_q <= best_deg_q;
      out_lag_q   <= ccss_pkg::LAGO_W'(best_lag_q);
      out_ratio_q <= ratio;
      short_q     <= 1'b0;
    end
  end

  ccss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram_first (
    .clk_i     (clk_i),
    .we_i      (store_we),
    .waddr_i   (AW'(cnt_q)),
    .wdata_i   (SAMPLE_BITS'($unsigned(sample_first_i))),
    .ra_addr_i (i_q),
    .rb_addr_i (j_q),
    .ra_data_o (x_rd),
    .rb_data_o (xj_rd)
  );

  ccss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram_second (
    .clk_i     (clk_i),
    .we_i      (store_we),
    .waddr_i   (AW'(cnt_q)),
    .wdata_i   (SAMPLE_BITS'($unsigned(sample_second_i))),
    .ra_addr_i (i_q),
    .rb_addr_i (j_q),
    .ra_data_o (y_rd),
    .rb_data_o (yj_rd)
  );

  ccss_coef u_coef (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (coef_start_q),
    .deg_i     (deg_q),
    .rt_mode_i (rt_mode_q),
    .cos_baz_i (cos_baz_q),
    .sin_baz_i (sin_baz_q),
    .done_o    (coef_done),
    .coef_o    (coef)
  );

  ccss_energy #(.SAMPLE_BITS(SAMPLE_BITS)) u_energy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q),
    .last_i  (rd_last_q),
    .clear_i (e_clear),
    .coef_i  (coef),
    .x_i     ($signed(x_rd)),
    .xj_i    ($signed(xj_rd)),
    .y_i     ($signed(y_rd)),
    .yj_i    ($signed(yj_rd)),
    .done_o  (e_done),
    .en_o    (en),
    .den_o   (den)
  );

  ccss_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmp_start),
    .e_i     (en),
    .d_i     (den),
    .be_i    (best_e_q),
    .bd_i    (best_d_q),
    .done_o  (cmp_done),
    .less_o  (cmp_less)
  );

  ccss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .e_i     (best_e_q),
    .d_i     (best_d_q),
    .done_o  (div_done),
    .ratio_o (ratio)
  );

  assign out_valid_o   = out_valid_q;
  assign best_angle_o  = out_angle_q;
  assign best_lag_o    = out_lag_q;
  assign best_ratio_o  = out_ratio_q;
  assign short_trace_o = short_q;

endmodule

// ===== sv/ccss_ram.sv =====
// generic single-write, dual-read ram with registered read data
// no dependencies
module ccss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    ra_addr_i,
  input  logic [AW-1:0]    rb_addr_i,
  output logic [WIDTH-1:0] ra_data_o,
  output logic [WIDTH-1:0] rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule

// ===== sv/ccss_coef.sv =====
// coefficient sequencer: sine lookup, products and, unless in rt mode, back-azimuth rotation
// on one shared multiplier; depends on ccss_pkg
module ccss_coef (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ccss_pkg::ANGLE_W-1:0]    deg_i,
  input  logic                            rt_mode_i,
  input  logic signed [ccss_pkg::CFG_W-1:0] cos_baz_i,
  input  logic signed [ccss_pkg::CFG_W-1:0] sin_baz_i,
  output logic                            done_o,
  output ccss_pkg::coef_t                 coef_o
);

  localparam int CW    = ccss_pkg::COEF_W;
  localparam int ACC_W = 2 * CW + 2;

  typedef enum logic [11:0] {
    CS_IDLE = 12'h001, CS_CC  = 12'h002, CS_SS  = 12'h004, CS_SC  = 12'h008,
    CS_A0M  = 12'h010, CS_A0  = 12'h020, CS_A1M = 12'h040, CS_A1  = 12'h080,
    CS_B0M  = 12'h100, CS_B0  = 12'h200, CS_B1M = 12'h400, CS_B1  = 12'h800
  } coef_step_e;

  coef_step_e step_q, step_d;
  logic signed [CW-1:0] s_q, c_q, a0p_q, a1p_q, b0p_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [CW-1:0] ma, mb, cb, sb, s_d, c_d;
  logic signed [2*CW-1:0] prod;
  logic signed [ACC_W-1:0] prod_x, sum_add, sum_sub;
  logic signed [CW-1:0] rnd_prod, rnd_add, rnd_sub;
  logic [6:0] s_idx, c_idx;
  logic c_neg;
  logic done_q;
  ccss_pkg::coef_t coef_q;

  assign cb = CW'(cos_baz_i);
  assign sb = CW'(sin_baz_i);

  // sine and cosine of the degree from the quarter-wave table
  always_comb begin
    if (deg_i <= 8'd90) begin
      s_idx = 7'(deg_i);
      c_idx = 7'(8'd90 - deg_i);
      c_neg = 1'b0;
    end else begin
      s_idx = 7'(8'd180 - deg_i);
      c_idx = 7'(deg_i - 8'd90);
      c_neg = 1'b1;
    end
    s_d = $signed(CW'(ccss_pkg::sine_lookup(s_idx)));
    c_d = $signed(CW'(ccss_pkg::sine_lookup(c_idx)));
    if (c_neg) begin
      c_d = -c_d;
    end
  end

  always_comb begin
    ma = s_q;
    mb = c_q;
    step_d = step_q;
    unique case (step_q)
      CS_IDLE: if (start_i) step_d = CS_CC;
      CS_CC:  begin ma = c_q; mb = c_q; step_d = CS_SS; end
      CS_SS:  begin ma = s_q; mb = s_q; step_d = CS_SC; end
      CS_SC:  begin ma = s_q; mb = c_q; step_d = rt_mode_i ? CS_IDLE : CS_A0M; end
      CS_A0M: begin ma = cb; mb = a0p_q; step_d = CS_A0; end
      CS_A0:  begin ma = sb; mb = b0p_q; step_d = CS_A1M; end
      CS_A1M: begin ma = cb; mb = a1p_q; step_d = CS_A1; end
      CS_A1:  begin ma = sb; mb = -b0p_q; step_d = CS_B0M; end
      CS_B0M: begin ma = sb; mb = a0p_q; step_d = CS_B0; end
      CS_B0:  begin ma = cb; mb = b0p_q; step_d = CS_B1M; end
      CS_B1M: begin ma = sb; mb = a1p_q; step_d = CS_B1; end
      CS_B1:  begin ma = cb; mb = -b0p_q; step_d = CS_IDLE; end
      default: step_d = CS_IDLE;
    endcase
  end

  assign prod     = ma * mb;
  assign prod_x   = ACC_W'(prod);
  assign sum_add  = acc_q + prod_x;
  assign sum_sub  = acc_q - prod_x;
  assign rnd_prod = CW'((prod_x + ACC_W'(16384)) >>> 15);
  assign rnd_add  = CW'((sum_add + ACC_W'(16384)) >>> 15);
  assign rnd_sub  = CW'((sum_sub + ACC_W'(16384)) >>> 15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= CS_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == CS_B1) || ((step_q == CS_SC) && rt_mode_i);
    end
  end

  always_ff @(posedge clk_i) begin
    case (step_q)
      CS_IDLE: if (start_i) begin s_q <= s_d; c_q <= c_d; end
      CS_CC:   a0p_q <= rnd_prod;
      CS_SS:   a1p_q <= rnd_prod;
      CS_SC: begin
        b0p_q <= rnd_prod;
        if (rt_mode_i) begin
          coef_q.a0 <= a0p_q;
          coef_q.a1 <= a1p_q;
          coef_q.b0 <= rnd_prod;
          coef_q.b1 <= -rnd_prod;
        end
      end
      CS_A0M, CS_A1M, CS_B0M, CS_B1M: acc_q <= prod_x;
      CS_A0:   coef_q.a0 <= rnd_add;
      CS_A1:   coef_q.a1 <= rnd_add;
      CS_B0:   coef_q.b0 <= rnd_sub;
      CS_B1:   coef_q.b1 <= rnd_sub;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign coef_o = coef_q;

endmodule

// ===== sv/ccss_energy.sv =====
// cross-convolution pipeline: products, rounding, squares and saturating
// energy sums for one grid point; depends on ccss_pkg
module ccss_energy #(
  parameter int SAMPLE_BITS = ccss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic                                last_i,
  input  logic                                clear_i,
  input  ccss_pkg::coef_t                     coef_i,
  input  logic signed [SAMPLE_BITS-1:0]       x_i,
  input  logic signed [SAMPLE_BITS-1:0]       xj_i,
  input  logic signed [SAMPLE_BITS-1:0]       y_i,
  input  logic signed [SAMPLE_BITS-1:0]       yj_i,
  output logic                                done_o,
  output logic [ccss_pkg::ENERGY_W-1:0]       en_o,
  output logic [ccss_pkg::DEN_W-1:0]          den_o
);

  localparam int CW     = ccss_pkg::COEF_W;
  localparam int EW     = ccss_pkg::ENERGY_W;
  localparam int PROD_W = CW + SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int EA_W   = SUM_W - 15;
  localparam int E_W    = EA_W + 1;
  localparam int SQ_W   = 2 * E_W;

  logic signed [CW-1:0] a0, a1, b0, b1;
  logic signed [PROD_W-1:0] pb0_q, pb1_q, pa0_q, pa1_q;
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [EA_W-1:0] ea_q, eb_q;
  logic signed [E_W-1:0] e;
  logic signed [SQ_W-1:0] sqe_q, sqa_q, sqb_q;
  logic [EW-1:0] en_q, ena_q, enb_q;
  logic v1_q, v2_q, v3_q, l1_q, l2_q, l3_q, done_q;

  assign a0 = coef_i.a0;
  assign a1 = coef_i.a1;
  assign b0 = coef_i.b0;
  assign b1 = coef_i.b1;

  assign sx = SUM_W'(pb0_q) + SUM_W'(pb1_q);
  assign sy = SUM_W'(pa0_q) + SUM_W'(pa1_q);
  assign e  = E_W'(ea_q) - E_W'(eb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, l1_q, l2_q, l3_q, done_q} <= '0;
    end else begin
      v1_q   <= valid_i;
      l1_q   <= valid_i & last_i;
      v2_q   <= v1_q;
      l2_q   <= l1_q;
      v3_q   <= v2_q;
      l3_q   <= l2_q;
      done_q <= v3_q & l3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pb0_q <= b0 * x_i;
    pb1_q <= b1 * xj_i;
    pa0_q <= a0 * y_i;
    pa1_q <= a1 * yj_i;
    ea_q  <= EA_W'((sx + SUM_W'(16384)) >>> 15);
    eb_q  <= EA_W'((sy + SUM_W'(16384)) >>> 15);
    sqe_q <= e * e;
    sqa_q <= SQ_W'(ea_q) * SQ_W'(ea_q);
    sqb_q <= SQ_W'(eb_q) * SQ_W'(eb_q);
    if (clear_i) begin
      en_q  <= '0;
      ena_q <= '0;
      enb_q <= '0;
    end else if (v3_q) begin
      en_q  <= ccss_pkg::sat_add(en_q,  EW'($unsigned(sqe_q)));
      ena_q <= ccss_pkg::sat_add(ena_q, EW'($unsigned(sqa_q)));
      enb_q <= ccss_pkg::sat_add(enb_q, EW'($unsigned(sqb_q)));
    end
  end

  assign done_o = done_q;
  assign en_o   = en_q;
  assign den_o  = {1'b0, ena_q} + {1'b0, enb_q};

endmodule

// ===== sv/ccss_cmp.sv =====
// exact ratio compare e/d < be/bd by two bit-serial cross products
// depends on ccss_pkg
module ccss_cmp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ccss_pkg::ENERGY_W-1:0] e_i,
  input  logic [ccss_pkg::DEN_W-1:0]    d_i,
  input  logic [ccss_pkg::ENERGY_W-1:0] be_i,
  input  logic [ccss_pkg::DEN_W-1:0]    bd_i,
  output logic                          done_o,
  output logic                          less_o
);

  localparam int EW = ccss_pkg::ENERGY_W;
  localparam int DW = ccss_pkg::DEN_W;
  localparam int PW = EW + DW;
  localparam int CNT_W = $clog2(DW);

  logic [EW-1:0] a1_q, a2_q;
  logic [DW-1:0] m1_q, m2_q;
  logic [PW-1:0] p1_q, p2_q;
  logic [CNT_W-1:0] cnt_q;
  logic busy_q, fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= busy_q && (cnt_q == CNT_W'(DW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // msb-first shift and add
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a1_q <= e_i;
      m1_q <= bd_i;
      a2_q <= be_i;
      m2_q <= d_i;
      p1_q <= '0;
      p2_q <= '0;
    end else if (busy_q) begin
      p1_q <= {p1_q[PW-2:0], 1'b0} + (m1_q[DW-1] ? PW'(a1_q) : '0);
      p2_q <= {p2_q[PW-2:0], 1'b0} + (m2_q[DW-1] ? PW'(a2_q) : '0);
      m1_q <= {m1_q[DW-2:0], 1'b0};
      m2_q <= {m2_q[DW-2:0], 1'b0};
    end
  end

  assign done_o = fin_q;
  assign less_o = p1_q < p2_q;

endmodule

// ===== sv/ccss_div.sv =====
// restoring divider for the saturated q1.16 ratio, one bit per cycle
// depends on ccss_pkg
module ccss_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ccss_pkg::ENERGY_W-1:0] e_i,
  input  logic [ccss_pkg::DEN_W-1:0]    d_i,
  output logic                          done_o,
  output logic [ccss_pkg::RATIO_W-1:0]  ratio_o
);

  localparam int DW  = ccss_pkg::DEN_W;
  localparam int RW  = DW + 1;
  localparam int RTW = ccss_pkg::RATIO_W;
  localparam int LAST = RTW + 1;

  logic [RW-1:0] rem_q, rem_sh;
  logic [DW-1:0] d_q;
  logic [RTW-1:0] q_q, ratio_q;
  logic [4:0] cnt_q;
  logic busy_q, sat_q, done_q;

  assign rem_sh = (cnt_q < 5'd2) ? rem_q : {rem_q[RW-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'(LAST));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'(LAST)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // step 0 takes the integer bit, step 1 checks overflow, then 16 fraction bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(e_i);
      d_q   <= d_i;
      q_q   <= '0;
      sat_q <= (d_i == '0);
    end else if (busy_q) begin
      if (cnt_q == 5'd1) begin
        if (rem_q >= RW'(d_q)) begin
          sat_q <= 1'b1;
        end
      end else if (cnt_q != 5'(LAST)) begin
        if (rem_sh >= RW'(d_q)) begin
          rem_q <= rem_sh - RW'(d_q);
          q_q   <= (cnt_q == 5'd0) ? RTW'(1) : {q_q[RTW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          q_q   <= (cnt_q == 5'd0) ? '0 : {q_q[RTW-2:0], 1'b0};
        end
      end else begin
        ratio_q <= sat_q ? ccss_pkg::RATIO_MAX : q_q;
      end
    end
  end

  assign done_o  = done_q;
  assign ratio_o = ratio_q;

endmodule

// ===== sv/ccss_checker.sv =====
// port-level checks of the splitting search and the bind that attaches them
// depends on ccss_pkg and the top level
module ccss_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic signed [ccss_pkg::FIELD_W-1:0] sample_first_i,
  input logic signed [ccss_pkg::FIELD_W-1:0] sample_second_i,
  input logic                               last_sample_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [ccss_pkg::ANGLE_W-1:0]       best_angle_o,
  input logic [ccss_pkg::LAGO_W-1:0]        best_lag_o,
  input logic [ccss_pkg::RATIO_W-1:0]       best_ratio_o,
  input logic                               short_trace_o,
  input logic                               cfg_we_i,
  input logic [1:0]                         cfg_index_i,
  input logic [ccss_pkg::CFG_W-1:0]         cfg_data_i
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && short_trace_o |->
      best_angle_o == '0 && best_lag_o == '0 && best_ratio_o == '0)
    else $error("short trace result with nonzero fields");

  a_point_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !short_trace_o |-> best_lag_o != '0 && best_angle_o < 8'd180)
    else $error("grid point out of range");

  // a new search never starts while a result is still held
  a_last_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_valid_i && last_sample_i |-> in_stall_o)
    else $error("last item taken while a result waits");

endmodule

bind cross_convolution_splitting_search ccss_checker u_ccss_checker (.*);

// ===== verif/tb_cross_convolution_splitting_search.sv =====
// self-checking testbench of the cross-convolution splitting grid search
// depends on ccss_pkg and cross_convolution_splitting_search
module tb_cross_convolution_splitting_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = ccss_pkg::MAX_SAMPLES_DEF;
  localparam int LAG_CEIL    = ccss_pkg::MAX_LAG_DEF;
  localparam int N_ANGLES    = ccss_pkg::ANGLE_STEPS_DEF;
  localparam int FW          = ccss_pkg::FIELD_W;
  localparam int CW          = ccss_pkg::CFG_W;
  localparam int AGW         = ccss_pkg::ANGLE_W;
  localparam int LGW         = ccss_pkg::LAGO_W;
  localparam int RTW         = ccss_pkg::RATIO_W;
  localparam longint CYCLE_LIMIT = 150_000_000;
  localparam logic [63:0] ACC_CAP = 64'h4000_0000_0000_0000;

  // one sample pair as it goes over the input channel
  typedef struct {
    logic signed [FW-1:0] first;
    logic signed [FW-1:0] second;
    logic                 last;
  } pair_t;

  // one search outcome
  typedef struct {
    logic [AGW-1:0] angle;
    logic [LGW-1:0] lag;
    logic [RTW-1:0] ratio;
    logic           short_tr;
  } split_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [FW-1:0] sample_first_i;
  logic signed [FW-1:0] sample_second_i;
  logic                 last_sample_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [AGW-1:0]       best_angle_o;
  logic [LGW-1:0]       best_lag_o;
  logic [RTW-1:0]       best_ratio_o;
  logic                 short_trace_o;
  logic                 cfg_we_i;
  logic [1:0]           cfg_index_i;
  logic [CW-1:0]        cfg_data_i;

  cross_convolution_splitting_search dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // items waiting for the driver, searches waiting for the monitor
  pair_t  pair_q[$];
  split_t split_q[$];
  int     err_cnt = 0;

  // idle rates in percent, changed per phase
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  // predictor copy of the registers
  logic           mode_rt  = 1'b1;
  logic [6:0]     lag_reg  = 7'd32;
  logic [CW-1:0]  cos_baz  = 16'h7fff;
  logic [CW-1:0]  sin_baz  = 16'h0000;

  // predictor copy of the trace stores
  longint trace_a [0:STORE_DEPTH-1];
  longint trace_b [0:STORE_DEPTH-1];
  int     loaded_n = 0;

  function automatic longint rnd15(longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic logic [63:0] acc_add(logic [63:0] acc, logic [63:0] v);
    if (v >= ACC_CAP || acc > ACC_CAP - v) return ACC_CAP;
    return acc + v;
  endfunction

  // floor(65536 * e / d) with saturation, zero denominator saturates
  function automatic logic [RTW-1:0] ratio_q216(logic [63:0] e, logic [63:0] d);
    logic [79:0] q;
    if (d == 64'd0) return ccss_pkg::RATIO_MAX;
    q = {e, 16'h0000} / {16'h0000, d};
    return (q > 80'd131071) ? ccss_pkg::RATIO_MAX : q[RTW-1:0];
  endfunction

  // full angle by lag grid search over the loaded trace
  function automatic split_t grid_search(int n);
    split_t      res;
    int          lim;
    longint      s, c, a0p, a1p, b0p, b1p, a0, a1, b0, b1, cb, sb;
    longint      ea, eb, ee;
    logic [63:0] en, ena, enb, den, best_e, best_d;
    logic [127:0] lhs, rhs;
    int          j;
    bit          first_pt;
    lim = int'(lag_reg);
    if (lim < 1) lim = 1;
    if (lim > LAG_CEIL) lim = LAG_CEIL;
    if (lim > n - 1) lim = n - 1;
    cb = longint'($signed(cos_baz));
    sb = longint'($signed(sin_baz));
    first_pt = 1'b1;
    best_e = '0;
    best_d = '0;
    res.angle = '0;
    res.lag = '0;
    res.short_tr = 1'b0;
    for (int k = 0; k < N_ANGLES; k++) begin
      if (k <= 90) begin
        s = longint'(ccss_pkg::SINE_ROM[k]);
        c = longint'(ccss_pkg::SINE_ROM[90 - k]);
      end else begin
        s = longint'(ccss_pkg::SINE_ROM[180 - k]);
        c = -longint'(ccss_pkg::SINE_ROM[k - 90]);
      end
      a0p = rnd15(c * c);
      a1p = rnd15(s * s);
      b0p = rnd15(s * c);
      b1p = -b0p;
      if (mode_rt) begin
        a0 = a0p; a1 = a1p; b0 = b0p; b1 = b1p;
      end else begin
        a0 = rnd15(cb * a0p + sb * b0p);
        a1 = rnd15(cb * a1p + sb * b1p);
        b0 = rnd15(sb * a0p - cb * b0p);
        b1 = rnd15(sb * a1p - cb * b1p);
      end
      for (int lg = 1; lg <= lim; lg++) begin
        en = '0; ena = '0; enb = '0;
        for (int i = 0; i < n; i++) begin
          j = (i >= lg) ? i - lg : i + n - lg;
          ea = rnd15(b0 * trace_a[i] + b1 * trace_a[j]);
          eb = rnd15(a0 * trace_b[i] + a1 * trace_b[j]);
          ee = ea - eb;
          en  = acc_add(en, 64'(ee * ee));
          ena = acc_add(ena, 64'(ea * ea));
          enb = acc_add(enb, 64'(eb * eb));
        end
        den = ena + enb;
        lhs = {64'd0, en} * {64'd0, best_d};
        rhs = {64'd0, best_e} * {64'd0, den};
        // strictly smaller ratio only, so the earlier point keeps a tie
        if (first_pt || lhs < rhs) begin
          first_pt = 1'b0;
          best_e = en;
          best_d = den;
          res.angle = AGW'(k);
          res.lag = LGW'(lg);
        end
      end
    end
    res.ratio = ratio_q216(best_e, best_d);
    return res;
  endfunction

  // store one accepted pair, run the search on the last one
  function automatic void take_pair(pair_t p);
    split_t r;
    int     n;
    if (loaded_n < STORE_DEPTH) begin
      trace_a[loaded_n] = longint'(p.first);
      trace_b[loaded_n] = longint'(p.second);
      loaded_n++;
    end
    if (p.last) begin
      n = loaded_n;
      loaded_n = 0;
      if (n < 2) begin
        r.angle = '0;
        r.lag = '0;
        r.ratio = '0;
        r.short_tr = 1'b1;
      end else begin
        r = grid_search(n);
      end
      split_q.push_back(r);
    end
  endfunction

  // driver: next item is loaded once the current one is taken or none is up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      sample_first_i  <= '0;
      sample_second_i <= '0;
      last_sample_i   <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        take_pair('{sample_first_i, sample_second_i, last_sample_i});
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pair_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          pair_t p;
          p = pair_q.pop_front();
          in_valid_i      <= 1'b1;
          sample_first_i  <= p.first;
          sample_second_i <= p.second;
          last_sample_i   <= p.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // monitor: random back-pressure, compare each result with the oldest search
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (split_q.size() == 0) begin
          report_mismatch("unexpected result, angle", int'(best_angle_o), -1);
        end else begin
          split_t w;
          w = split_q.pop_front();
          if (best_angle_o !== w.angle)
            report_mismatch("best_angle", int'(best_angle_o), int'(w.angle));
          if (best_lag_o !== w.lag)
            report_mismatch("best_lag", int'(best_lag_o), int'(w.lag));
          if (best_ratio_o !== w.ratio)
            report_mismatch("best_ratio", int'(best_ratio_o), int'(w.ratio));
          if (short_trace_o !== w.short_tr)
            report_mismatch("short_trace", int'(short_trace_o), int'(w.short_tr));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // watchdog
  longint cyc = 0;
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // register write, only ever called while the block is idle
  task automatic cfg_write(logic [1:0] idx, logic [CW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      ccss_pkg::CFG_RT_MODE: mode_rt = val[0];
      ccss_pkg::CFG_MAX_LAG: lag_reg = val[6:0];
      ccss_pkg::CFG_COS_BAZ: cos_baz = val;
      ccss_pkg::CFG_SIN_BAZ: sin_baz = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic rt, logic [6:0] lg, logic [CW-1:0] cb, logic [CW-1:0] sb);
    cfg_write(ccss_pkg::CFG_RT_MODE, CW'(rt));
    cfg_write(ccss_pkg::CFG_MAX_LAG, CW'(lg));
    cfg_write(ccss_pkg::CFG_COS_BAZ, cb);
    cfg_write(ccss_pkg::CFG_SIN_BAZ, sb);
  endtask

  // wait for every item taken and every result seen, then let the block settle
  task automatic drain();
    while (pair_q.size() != 0 || in_valid_i || split_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [FW-1:0] any_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return FW'($signed($urandom_range(0, 64)) - 32);
      default: return FW'($urandom);
    endcase
  endfunction

  // kind: 0 random, 1 all zero, 2 alternating extremes
  task automatic push_trace(int n, int kind);
    pair_t p;
    for (int i = 0; i < n; i++) begin
      case (kind)
        1: begin p.first = '0; p.second = '0; end
        2: begin
          p.first  = i[0] ? 16'sh7fff : -16'sh8000;
          p.second = i[1] ? -16'sh8000 : 16'sh7fff;
        end
        default: begin p.first = any_sample(); p.second = any_sample(); end
      endcase
      p.last = (i == n - 1);
      pair_q.push_back(p);
    end
  endtask

  function automatic logic [CW-1:0] any_trig();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return CW'($urandom);
    endcase
  endfunction

  // one random phase: random registers, then traces until about n_items items
  task automatic random_phase(int n_items);
    logic [6:0] lg;
    int         pushed, len, r;
    r = $urandom_range(0, 9);
    if (r < 7) lg = 7'($urandom_range(0, 1));
    else if (r == 7) lg = 7'd2;
    else lg = 7'($urandom_range(3, 127));
    set_regs(1'($urandom_range(0, 1)), lg, any_trig(), any_trig());
    pushed = 0;
    while (pushed < n_items) begin
      r = $urandom_range(0, 9);
      // long lags only with short traces to bound the search time
      if (lg > 2) len = $urandom_range(1, 6);
      else if (r == 0) len = 1;
      else if (r < 8) len = $urandom_range(2, 30);
      else len = $urandom_range(31, 60);
      push_trace(len, 0);
      pushed += len;
    end
    drain();
  endtask

  initial begin
    cfg_we_i    = 1'b0;
    cfg_index_i = ccss_pkg::CFG_RT_MODE;
    cfg_data_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    snd_idle_pct = 22;
    rcv_idle_pct = 72;

    // directed: reset registers, single-pair short trace, silent trace, extremes, random trace
    push_trace(1, 0);
    push_trace(3, 1);
    push_trace(4, 2);
    push_trace(5, 0);
    drain();
    // north/east mode, lag zero counts as one, extreme back-azimuth
    set_regs(1'b0, 7'd0, 16'h8000, 16'h7fff);
    push_trace(3, 2);
    drain();
    // lag above the ceiling, clamped to the trace length
    set_regs(1'b0, 7'd127, 16'h7fff, 16'h8000);
    push_trace(4, 0);
    drain();
    // zero coefficients give a zero denominator everywhere
    set_regs(1'b0, 7'd64, 16'h0000, 16'h0000);
    push_trace(3, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 4) begin
        snd_idle_pct = 22; rcv_idle_pct = 72;
      end else if (ph < 8) begin
        snd_idle_pct = 72; rcv_idle_pct = 22;
      end else begin
        snd_idle_pct = 0; rcv_idle_pct = 0;
      end
      random_phase(120);
    end

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== cross_convolution_splitting_search.f =====
sv/ccss_pkg.sv
sv/ccss_ram.sv
sv/ccss_coef.sv
sv/ccss_energy.sv
sv/ccss_cmp.sv
sv/ccss_div.sv
sv/cross_convolution_splitting_search.sv
sv/ccss_checker.sv
verif/tb_cross_convolution_splitting_search.sv
